@@ rtl/mppt_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mppt_pkg: shared types and constants of the mouse packet position tracker
// Holds the packet phase codes, register indexes, field widths, reset
// positions and the packed layout of a result item.
// ----------------------------------------------------------------------------
package mppt_pkg;

	// Field and register widths fixed by the stream format
	localparam int BYTE_W = 8;
	localparam int CFG_W  = 12;
	localparam int OUT_W  = 12;
	localparam int BTN_W  = 2;
	localparam int TDATA_OUT_W = 32;

	// Packet phase codes
	localparam logic [1:0] PH_HDR = 2'd0;
	localparam logic [1:0] PH_DX  = 2'd1;
	localparam logic [1:0] PH_DY  = 2'd2;

	// Bytes dropped after a bad header
	localparam logic [1:0] DROP_LEN = 2'd3;

	// Header bit positions
	localparam int HDR_SYNC_BIT = 3;
	localparam int HDR_XNEG_BIT = 4;
	localparam int HDR_YNEG_BIT = 5;

	// Configuration register indexes
	localparam logic REG_SCREEN_W = 1'b0;
	localparam logic REG_SCREEN_H = 1'b1;

	// Reset values
	localparam logic [CFG_W-1:0] RESET_SCREEN_W = 12'd1920;
	localparam logic [CFG_W-1:0] RESET_SCREEN_H = 12'd1080;
	localparam int RESET_POS_X = 800;
	localparam int RESET_POS_Y = 400;

	// One result item, last field in the lowest bits
	typedef struct packed {
		logic [TDATA_OUT_W-OUT_W-OUT_W-BTN_W-1:0] pad;
		logic [BTN_W-1:0]                        buttons;
		logic [OUT_W-1:0]                        pos_y;
		logic [OUT_W-1:0]                        pos_x;
	} result_t;

endpackage

@@ rtl/mouse_packet_position_tracker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mouse_packet_position_tracker: 3-byte mouse packet decoder with position
// Takes packet bytes (header, dx, dy), drops bad headers with the three
// bytes after them, and issues one clamped position per good packet.
// ----------------------------------------------------------------------------
// Path: the third byte of a packet passes the input register, then the
// result register, from which its result item leaves.
// Throughput: one byte per cycle while the result register is free or being
// emptied; the input register and the result register let a new byte in
// while a finished result still waits for m_tready. Reset (arst_n low,
// asynchronous): expect a header, no drop pending, position 800/400, screen 1920 x 1080, both stages empty.
module mouse_packet_position_tracker
	import mppt_pkg::*;
#(
	parameter int COORD_WIDTH = 12
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// Configuration write port
	input  logic                   cfg_we,
	input  logic                   cfg_index,
	input  logic [CFG_W-1:0]       cfg_data,
	// Byte stream in
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [BYTE_W-1:0]      s_tdata,   // [7:0] data_byte
	// Result stream out
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [TDATA_OUT_W-1:0] m_tdata    // [11:0] pos_x, [23:12] pos_y,
	                                          // [25:24] buttons, rest zero
);

	// Arithmetic width: room for the largest coordinate or limit, plus a
	// carry bit and a sign bit
	localparam int VW = ((COORD_WIDTH > CFG_W) ? COORD_WIDTH : CFG_W) + 2;
	localparam logic signed [VW-1:0] COORD_MAX = VW'((1 << COORD_WIDTH) - 1);
	localparam logic signed [VW-1:0] NEG_OFFSET = VW'(256);

	// Add a 9-bit two's complement delta, then clamp to 0..limit, the limit
	// itself saturated at the coordinate range
	function automatic logic [COORD_WIDTH-1:0] move_axis(
		input logic [COORD_WIDTH-1:0] pos,
		input logic [BYTE_W-1:0]      delta,
		input logic                   neg,
		input logic [CFG_W-1:0]       limit
	);
		logic signed [VW-1:0] v;
		logic signed [VW-1:0] lim;
		v   = signed'(VW'(pos)) + signed'(VW'(delta));
		if (neg) begin
			v = v - NEG_OFFSET;
		end
		lim = signed'(VW'(limit));
		if (lim > COORD_MAX) begin
			lim = COORD_MAX;
		end
		if (v < 0) begin
			v = '0;
		end else if (v > lim) begin
			v = lim;
		end
		return v[COORD_WIDTH-1:0];
	endfunction

	// Configuration
	logic [CFG_W-1:0]       screen_w_q;
	logic [CFG_W-1:0]       screen_h_q;

	// Packet state
	logic [1:0]             phase_q;
	logic [1:0]             drop_q;
	logic [BYTE_W-1:0]      hdr_q;
	logic [BYTE_W-1:0]      dx_q;
	logic [COORD_WIDTH-1:0] pos_x_q;
	logic [COORD_WIDTH-1:0] pos_y_q;

	// Input stage
	logic                   valid_s1;
	logic [BYTE_W-1:0]      byte_s1;

	// Result stage
	logic                   valid_s2;
	result_t                result_s2;

	// Next-state logic of the item in the input stage
	logic                   adv;
	logic                   emit;
	logic [1:0]             phase_d;
	logic [1:0]             drop_d;
	logic [BYTE_W-1:0]      hdr_d;
	logic [BYTE_W-1:0]      dx_d;
	logic [COORD_WIDTH-1:0] pos_x_d;
	logic [COORD_WIDTH-1:0] pos_y_d;
	logic [BTN_W-1:0]       btn;

	// The input stage moves on whenever the result register is free or
	// being emptied this cycle
	assign adv      = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || adv;

	assign btn = hdr_q[BTN_W-1:0];

	always_comb begin
		phase_d = phase_q;
		drop_d  = drop_q;
		hdr_d   = hdr_q;
		dx_d    = dx_q;
		pos_x_d = pos_x_q;
		pos_y_d = pos_y_q;
		emit    = 1'b0;
		if (drop_q != 2'd0) begin
			// Resync: swallow the byte, count down
			drop_d = drop_q - 2'd1;
		end else begin
			unique case (phase_q)
				PH_DX: begin
					dx_d    = byte_s1;
					phase_d = PH_DY;
				end
				PH_DY: begin
					phase_d = PH_HDR;
					emit    = 1'b1;
					// Any button down: report buttons, hold the position
					if (btn == '0) begin
						pos_x_d = move_axis(pos_x_q, dx_q, hdr_q[HDR_XNEG_BIT],
							screen_w_q);
						pos_y_d = move_axis(pos_y_q, byte_s1, hdr_q[HDR_YNEG_BIT],
							screen_h_q);
					end
				end
				default: begin
					// Header expected; the unused phase code lands here too
					phase_d = PH_HDR;
					if (!byte_s1[HDR_SYNC_BIT]) begin
						drop_d = DROP_LEN;
					end else begin
						hdr_d   = byte_s1;
						phase_d = PH_DX;
					end
				end
			endcase
		end
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			screen_w_q <= RESET_SCREEN_W;
			screen_h_q <= RESET_SCREEN_H;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SCREEN_W: screen_w_q <= cfg_data;
				REG_SCREEN_H: screen_h_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Input stage: hold the byte until it can advance
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
		end
	end

	// Packet state: update only as an item leaves the input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HDR;
			drop_q  <= 2'd0;
			hdr_q   <= '0;
			dx_q    <= '0;
			pos_x_q <= COORD_WIDTH'(RESET_POS_X);
			pos_y_q <= COORD_WIDTH'(RESET_POS_Y);
		end else if (adv) begin
			phase_q <= phase_d;
			drop_q  <= drop_d;
			hdr_q   <= hdr_d;
			dx_q    <= dx_d;
			pos_x_q <= pos_x_d;
			pos_y_q <= pos_y_d;
		end
	end

	// Result stage: load on a completed packet, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv && emit) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && emit) begin
			result_s2.pad     <= '0;
			result_s2.buttons <= btn;
			result_s2.pos_x   <= OUT_W'(pos_x_d);
			result_s2.pos_y   <= OUT_W'(pos_y_d);
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = result_s2;

endmodule
